### hw/rtl/floppy_gap3_gap4b_calculator_top_defines.svh
// Assertion macros used by the checker file.
`ifndef FLOPPY_GAP3_GAP4B_CALCULATOR_TOP_DEFINES_SVH
`define FLOPPY_GAP3_GAP4B_CALCULATOR_TOP_DEFINES_SVH

// A property checked on every rising clock edge outside of reset.
`define FGC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fgc assertion failed");

// An implication checked on every rising clock edge outside of reset.
`define FGC_ASSERT_IMP(lbl, ante, cons) \
  `FGC_ASSERT(lbl, (ante) |-> (cons))

`endif

### hw/rtl/fgc_pkg.sv
`default_nettype none

package fgc_pkg;

  localparam int unsigned CapW     = 16;
  localparam int unsigned CntW     = 8;
  localparam int unsigned BytesW   = 16;
  localparam int unsigned Gap3W    = 8;
  localparam int unsigned Gap4bW   = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned SumW     = BytesW + 1;
  localparam int unsigned ProdW    = CntW + SumW;
  localparam int unsigned DshW     = CntW + Gap3W - 1;
  localparam int unsigned NumCells = Gap3W;
  localparam int unsigned InDataW  = CapW + CntW + BytesW;
  localparam int unsigned OutFldW  = Gap3W + Gap4bW + StatusW;
  localparam int unsigned OutDataW = ((OutFldW + 7) / 8) * 8;

  localparam int unsigned SectorCrcBytes = 2;
  localparam logic [SumW-1:0] SectorOvhMfm =
    SumW'(12 + 4 + 4 + 2 + 22 + 12 + 4 + SectorCrcBytes);
  localparam logic [SumW-1:0] SectorOvhFm =
    SumW'(6 + 1 + 4 + 2 + 11 + 6 + 1 + SectorCrcBytes);
  localparam logic [ProdW-1:0] TrackOvhMfm = ProdW'(80 + 12 + 4 + 50);
  localparam logic [ProdW-1:0] TrackOvhFm  = ProdW'(40 + 6 + 1 + 26);

  typedef enum logic [StatusW-1:0] {
    ST_FITS       = 2'd0,
    ST_NO_SECTORS = 2'd1,
    ST_NO_FIT     = 2'd2
  } fgc_status_e;

  typedef struct packed {
    logic [CapW-1:0]  rem;
    logic [DshW-1:0]  dsh;
    logic [Gap3W-1:0] quo;
    fgc_status_e      status;
  } fgc_div_t;

endpackage

`default_nettype wire

### hw/rtl/fgc_front.sv
`default_nettype none

module fgc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [fgc_pkg::CapW-1:0]    cap_i,
  input  logic [fgc_pkg::CntW-1:0]    cnt_i,
  input  logic [fgc_pkg::BytesW-1:0]  bytes_i,
  input  logic                        mfm_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output fgc_pkg::fgc_div_t           data_o
);
  import fgc_pkg::*;

  logic             a_valid_q;
  logic [ProdW-1:0] a_prod_q, a_prod_d;
  logic [CapW-1:0]  a_cap_q;
  logic [CntW-1:0]  a_cnt_q;
  logic             a_mfm_q;
  logic             a_ready;
  logic [SumW-1:0]  sum_d;

  logic             b_valid_q;
  fgc_div_t         b_data_q, b_data_d;
  logic             b_ready;
  logic [ProdW-1:0] used;
  logic             fits;
  logic             zero;

  assign a_ready = !a_valid_q || b_ready;
  assign b_ready = !b_valid_q || ready_i;
  assign ready_o = a_ready;

  assign sum_d    = {1'b0, bytes_i} + (mfm_i ? SectorOvhMfm : SectorOvhFm);
  assign a_prod_d = {{SumW{1'b0}}, cnt_i} * {{CntW{1'b0}}, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_prod_q <= a_prod_d;
      a_cap_q  <= cap_i;
      a_cnt_q  <= cnt_i;
      a_mfm_q  <= mfm_i;
    end
  end

  assign used = a_prod_q + (a_mfm_q ? TrackOvhMfm : TrackOvhFm);
  assign fits = used < {{(ProdW-CapW){1'b0}}, a_cap_q};
  assign zero = a_cnt_q == '0;

  always_comb begin
    b_data_d.dsh = {a_cnt_q, {(Gap3W-1){1'b0}}};
    b_data_d.quo = '0;
    b_data_d.rem = '0;
    if (zero) begin
      b_data_d.status = ST_NO_SECTORS;
    end else if (!fits) begin
      b_data_d.status = ST_NO_FIT;
    end else begin
      b_data_d.status = ST_FITS;
      b_data_d.rem    = a_cap_q - used[CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

endmodule

`default_nettype wire

### hw/rtl/fgc_cell.sv
`default_nettype none

module fgc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fgc_pkg::fgc_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fgc_pkg::fgc_div_t data_o
);
  import fgc_pkg::*;

  logic     valid_q;
  fgc_div_t data_q, data_d;
  logic     take;

  assign ready_o = !valid_q || ready_i;

  // One restoring step: the shifted divisor halves as it moves down the row.
  always_comb begin
    data_d     = data_i;
    take       = data_i.rem >= {1'b0, data_i.dsh};
    if (take) begin
      data_d.rem = data_i.rem - {1'b0, data_i.dsh};
    end
    data_d.quo = {data_i.quo[Gap3W-2:0], take};
    data_d.dsh = data_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### hw/rtl/floppy_gap3_gap4b_calculator_top.sv
// Channel   Direction  tdata (low bit up)                         tuser
// s_axis    in         trk_cap, sec_cnt, sec_bytes                mfm_mode
// m_axis    out        gap3_length, gap4b_length, status          none
//
// One transaction is accepted per cycle when the output side keeps up.
// The pipeline is a multiply stage, an overhead and fit stage, and a row
// of eight divider cells, each producing one bit of gap 3.
// Every stage holds its transaction under backpressure and takes a new one
// when it is empty or its neighbor advances. Reset empties all stages.
`default_nettype none

module floppy_gap3_gap4b_calculator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // trk_cap[15:0], sec_cnt[23:16], sec_bytes[39:24]
  input  logic [fgc_pkg::InDataW-1:0]    s_axis_tdata,
  // mfm_mode[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // gap3_length[7:0], gap4b_length[23:8], status[25:24], zero fill above
  output logic [fgc_pkg::OutDataW-1:0]   m_axis_tdata
);
  import fgc_pkg::*;

  logic [NumCells:0] chain_valid;
  logic [NumCells:0] chain_ready;
  fgc_div_t          chain_data [NumCells+1];
  fgc_div_t          last;
  logic              fits;

  fgc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cap_i   (s_axis_tdata[CapW-1:0]),
    .cnt_i   (s_axis_tdata[CapW+CntW-1:CapW]),
    .bytes_i (s_axis_tdata[InDataW-1:CapW+CntW]),
    .mfm_i   (s_axis_tuser),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    fgc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign chain_ready[NumCells] = m_axis_tready;
  assign m_axis_tvalid         = chain_valid[NumCells];

  assign last = chain_data[NumCells];
  assign fits = last.status == ST_FITS;

  assign m_axis_tdata = {{(OutDataW-OutFldW){1'b0}},
                         last.status,
                         fits ? last.rem : {Gap4bW{1'b0}},
                         fits ? last.quo : {Gap3W{1'b0}}};

endmodule

`default_nettype wire

### hw/rtl/fgc_checker.sv
`default_nettype none

`include "floppy_gap3_gap4b_calculator_top_defines.svh"

module fgc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [fgc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [fgc_pkg::OutDataW-1:0] m_axis_tdata
);
  import fgc_pkg::*;

  logic [StatusW-1:0] st;
  logic               st_ok;
  logic               no_fit_zero;
  logic               in_seen;

  assign st          = m_axis_tdata[OutFldW-1:Gap3W+Gap4bW];
  assign st_ok       = (st == ST_FITS) || (st == ST_NO_SECTORS) || (st == ST_NO_FIT);
  assign no_fit_zero = m_axis_tdata[Gap3W+Gap4bW-1:0] == '0;
  assign in_seen     = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tuser);

  `FGC_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 $stable(m_axis_tdata))
  `FGC_ASSERT_IMP(a_status_code, m_axis_tvalid, st_ok)
  `FGC_ASSERT_IMP(a_no_fit_zero, m_axis_tvalid && st != ST_FITS, no_fit_zero)
  `FGC_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready || !in_seen)

endmodule

bind floppy_gap3_gap4b_calculator_top fgc_checker u_fgc_checker (.*);

`default_nettype wire
